// ===== src/utlb_pkg.sv =====
// Shared types, constants and helpers for the micro-TLB tag store.
package utlb_pkg;

  localparam int ENTRIES = 64;
  localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int VPN_W   = 22;
  localparam int ASID_W  = 8;
  localparam int PSIZE_W = 2;
  localparam int ACT_W   = 2;
  localparam int OSLOT_W = 6;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_FILL   = 2'd1,
    ACT_DIRTY  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_t;

  // One recency-list position: the slot it names and that slot's tag.
  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [VPN_W-1:0]   vpn;
    logic [ASID_W-1:0]  asid;
    logic [PSIZE_W-1:0] psize;
    logic               dirty;
    logic               valid;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Page-number bits kept for each page size (1K, 4K, 64K, 1M).
  function automatic logic [VPN_W-1:0] page_keep(input logic [PSIZE_W-1:0] size);
    logic [VPN_W-1:0] keep;
    unique case (size)
      2'd0:    keep = 22'h3FFFFF;
      2'd1:    keep = 22'h3FFFFC;
      2'd2:    keep = 22'h3FFFC0;
      default: keep = 22'h3FFC00;
    endcase
    return keep;
  endfunction

  // Slot number reduced or zero-extended to the result width.
  function automatic logic [OSLOT_W-1:0] slot_out(input logic [SLOT_W-1:0] s);
    logic [31:0] wide;
    wide = 32'(s);
    return wide[OSLOT_W-1:0];
  endfunction

endpackage

// ===== src/utlb_cell.sv =====
// One recency-list position: holds an entry, compares it, shifts from its neighbor.
module utlb_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [utlb_pkg::SLOT_W-1:0]   reset_slot,
  input  logic                          cmp_en,
  input  logic [utlb_pkg::VPN_W-1:0]    req_vpn,
  input  logic [utlb_pkg::ASID_W-1:0]   req_asid,
  input  logic                          shift_en,
  input  utlb_pkg::entry_t              prev_entry,
  output utlb_pkg::entry_t              entry,
  output logic                          match
);
  import utlb_pkg::*;

  logic match_next;

  assign match_next = entry.valid && (entry.asid == req_asid) &&
                      (entry.vpn == (req_vpn & page_keep(entry.psize)));

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.slot  <= reset_slot;
      entry.dirty <= 1'b0;
      entry.valid <= 1'b0;
    end else if (shift_en) begin
      entry <= prev_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_en) begin
      match <= match_next;
    end
  end

endmodule

// ===== src/utlb_front_sel.sv =====
// Picks the most recent matching position, builds shift enables and the chosen entry.
module utlb_front_sel (
  input  logic [utlb_pkg::ENTRIES-1:0] match,
  input  utlb_pkg::entry_t             entries [utlb_pkg::ENTRIES],
  output logic [utlb_pkg::ENTRIES-1:0] shift_en,
  output logic                         hit_any,
  output utlb_pkg::entry_t             chosen
);
  import utlb_pkg::*;

  logic [ENTRIES-1:0] prefix;
  logic [ENTRIES-1:0] seen_before;
  logic [ENTRIES-1:0] first;
  logic [ENTRY_W-1:0] acc;

  // Log-depth inclusive prefix OR over positions.
  always_comb begin
    prefix = match;
    for (int k = 1; k < ENTRIES; k = k * 2) begin
      prefix = prefix | (prefix << k);
    end
  end

  assign seen_before = prefix << 1;
  assign first       = match & ~seen_before;
  assign hit_any     = prefix[ENTRIES-1];
  // Positions up to and including the hit take their neighbor's entry.
  assign shift_en    = {ENTRIES{hit_any}} & ~seen_before;

  always_comb begin
    acc = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      acc = acc | (entries[i] & {ENTRY_W{first[i]}});
    end
  end

  assign chosen = entry_t'(acc);

endmodule

// ===== src/utlb_tag_match_with_lru.sv =====
// Top level of the fully associative micro-TLB tag store with LRU ordering.
//
// Request channel: req_valid / req_stall with action, virt_addr, space_id and
// page_size. Response channel: resp_valid / resp_stall with hit and slot.
// A transfer happens on a rising edge with valid high and stall low.
// The store is a row of cells, one per recency position, front = most recent.
// Each cell compares its own entry; the hit (or, for a fill, the last cell)
// moves to the front while the cells ahead of it shift back by one.
// An accepted request passes the compare state, where each cell registers its
// match, and the update state, where the row shifts and the response register
// loads once it is free. The next request can be taken in the update state, not in the compare state.
// A stalled response holds in its register; the shift cycle of the next
// request waits for it, and req_stall stays high meanwhile.
// Reset (rst, synchronous): all entries invalid and clean, position i holds
// slot i, no response pending. Tags are unknown until filled.
// Action code 3 and misses change nothing and answer hit 0, slot 0.
module utlb_tag_match_with_lru (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic [utlb_pkg::ACT_W-1:0]     action,
  input  logic [31:0]                    virt_addr,
  input  logic [utlb_pkg::ASID_W-1:0]    space_id,
  input  logic [utlb_pkg::PSIZE_W-1:0]   page_size,
  output logic                           resp_valid,
  input  logic                           resp_stall,
  output logic                           hit,
  output logic [utlb_pkg::OSLOT_W-1:0]   slot
);
  import utlb_pkg::*;

  state_t state, state_next;

  // request held for its compare and shift cycles
  action_t            cur_action;
  logic [VPN_W-1:0]   cur_vpn;
  logic [ASID_W-1:0]  cur_asid;
  logic [PSIZE_W-1:0] cur_psize;

  logic req_xfer;
  logic out_free;
  logic cmp_en;
  logic upd_en;

  entry_t             entries [ENTRIES];
  entry_t             prev_in [ENTRIES];
  logic [ENTRIES-1:0] match_raw;
  logic [ENTRIES-1:0] match_eff;
  logic [ENTRIES-1:0] shift_vec;
  logic               hit_any;
  entry_t             chosen;
  entry_t             front;
  logic               is_fill;
  logic               is_look;

  assign out_free = !resp_valid || !resp_stall;
  assign req_xfer = req_valid && !req_stall;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (req_xfer) state_next = ST_CMP;
      ST_CMP:  state_next = ST_UPD;
      ST_UPD: begin
        if (out_free) state_next = req_xfer ? ST_CMP : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    req_stall = 1'b1;
    cmp_en    = 1'b0;
    upd_en    = 1'b0;
    unique case (state)
      ST_IDLE: req_stall = 1'b0;
      ST_CMP:  cmp_en = 1'b1;
      ST_UPD: begin
        upd_en    = out_free;
        req_stall = !out_free;
      end
      default: req_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_xfer) begin
      cur_action <= action_t'(action);
      cur_vpn    <= virt_addr[31:10];
      cur_asid   <= space_id;
      cur_psize  <= page_size;
    end
  end

  assign is_fill = (cur_action == ACT_FILL);
  assign is_look = (cur_action == ACT_LOOKUP) || (cur_action == ACT_DIRTY);

  // a fill always takes the least recent position
  always_comb begin
    match_eff = '0;
    if (is_fill) begin
      match_eff[ENTRIES-1] = 1'b1;
    end else if (is_look) begin
      match_eff = match_raw;
    end
  end

  utlb_front_sel u_sel (
    .match    (match_eff),
    .entries  (entries),
    .shift_en (shift_vec),
    .hit_any  (hit_any),
    .chosen   (chosen)
  );

  // entry written into the front position
  always_comb begin
    front = chosen;
    if (is_fill) begin
      front.vpn   = cur_vpn & page_keep(cur_psize);
      front.asid  = cur_asid;
      front.psize = cur_psize;
      front.dirty = 1'b0;
      front.valid = 1'b1;
    end else if (cur_action == ACT_DIRTY) begin
      front.dirty = 1'b1;
    end
  end

  always_comb begin
    prev_in[0] = front;
    for (int i = 1; i < ENTRIES; i++) begin
      prev_in[i] = entries[i-1];
    end
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    utlb_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .reset_slot (SLOT_W'(g)),
      .cmp_en     (cmp_en),
      .req_vpn    (cur_vpn),
      .req_asid   (cur_asid),
      .shift_en   (upd_en && shift_vec[g]),
      .prev_entry (prev_in[g]),
      .entry      (entries[g]),
      .match      (match_raw[g])
    );
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      resp_valid <= 1'b0;
    end else if (upd_en) begin
      resp_valid <= 1'b1;
    end else if (!resp_stall) begin
      resp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en) begin
      hit  <= hit_any;
      slot <= hit_any ? slot_out(chosen.slot) : '0;
    end
  end

endmodule

// ===== src/utlb_checker.sv =====
// Port-level checks for the micro-TLB, bound to the top level.
module utlb_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_stall,
  input logic                         resp_valid,
  input logic                         resp_stall,
  input logic                         hit,
  input logic [utlb_pkg::OSLOT_W-1:0] slot
);

  // a miss always reports slot zero
  a_miss_slot: assert property (@(posedge clk) disable iff (rst)
    resp_valid && !hit |-> slot == '0)
    else $error("miss with nonzero slot");

  // no two request transfers on consecutive edges
  a_req_spacing: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("requests accepted back to back");

  // a fresh response must trace back to an earlier request transfer
  a_resp_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(resp_valid) |-> $past(req_valid && !req_stall, 3))
    else $error("response without matching request");

  // stalled response holds
  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    resp_valid && resp_stall |=> resp_valid && $stable(hit) && $stable(slot))
    else $error("stalled response changed");

endmodule

bind utlb_tag_match_with_lru utlb_checker u_utlb_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req_valid),
  .req_stall  (req_stall),
  .resp_valid (resp_valid),
  .resp_stall (resp_stall),
  .hit        (hit),
  .slot       (slot)
);

// ===== dv/utlb_tag_match_with_lru_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the micro-TLB tag store with LRU replacement.
module utlb_tag_match_with_lru_test;
  import utlb_pkg::*;

  // Worst case is far below this: about 1900 transfers, each with geometric
  // sender gaps and receiver stalls.
  localparam int CYCLE_LIMIT = 400000;
  // Pages remembered for reuse; deeper than the store so some are evicted.
  localparam int POOL_DEPTH  = 96;

  typedef struct {
    logic               hit;
    logic [OSLOT_W-1:0] slot;
  } tlb_answer_t;

  typedef struct {
    logic [31:0]        addr;
    logic [ASID_W-1:0]  asid;
    logic [PSIZE_W-1:0] size;
  } page_rec_t;

  logic                clk        = 1'b0;
  logic                rst        = 1'b1;
  logic                req_valid  = 1'b0;
  logic                req_stall;
  logic [ACT_W-1:0]    action     = ACT_LOOKUP;
  logic [31:0]         virt_addr  = '0;
  logic [ASID_W-1:0]   space_id   = '0;
  logic [PSIZE_W-1:0]  page_size  = '0;
  logic                resp_valid;
  logic                resp_stall = 1'b0;
  logic                hit;
  logic [OSLOT_W-1:0]  slot;

  int unsigned idle_pct    = 0;
  int unsigned stall_pct   = 0;
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;

  tlb_answer_t expected_answers[$];
  tlb_answer_t oldest;
  page_rec_t   recent_fills[$];

  // Shadow copy of the tag store and its recency list (position 0 = newest).
  logic [VPN_W-1:0]   shadow_vpn   [ENTRIES];
  logic [ASID_W-1:0]  shadow_asid  [ENTRIES];
  logic [PSIZE_W-1:0] shadow_psize [ENTRIES];
  bit                 shadow_dirty [ENTRIES];
  bit                 shadow_valid [ENTRIES];
  int unsigned        shadow_lru   [ENTRIES];

  utlb_tag_match_with_lru uut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .action     (action),
    .virt_addr  (virt_addr),
    .space_id   (space_id),
    .page_size  (page_size),
    .resp_valid (resp_valid),
    .resp_stall (resp_stall),
    .hit        (hit),
    .slot       (slot)
  );

  always #10 clk = ~clk;

  // Address bits below the page boundary for each page size (1K/4K/64K/1M).
  function automatic int page_span(logic [PSIZE_W-1:0] size);
    case (size)
      2'd0:    return 10;
      2'd1:    return 12;
      2'd2:    return 16;
      default: return 20;
    endcase
  endfunction

  // Page number of an address as stored for a page of the given size.
  function automatic logic [VPN_W-1:0] masked_vpn(logic [31:0] addr,
                                                  logic [PSIZE_W-1:0] size);
    logic [VPN_W-1:0] vpn;
    vpn = addr[31:10];
    case (size)
      2'd1:    vpn[1:0] = '0;
      2'd2:    vpn[5:0] = '0;
      2'd3:    vpn[9:0] = '0;
      default: ;
    endcase
    return vpn;
  endfunction

  task automatic shadow_reset();
    int i;
    for (i = 0; i < ENTRIES; i++) begin
      shadow_vpn[i]   = '0;
      shadow_asid[i]  = '0;
      shadow_psize[i] = '0;
      shadow_dirty[i] = 1'b0;
      shadow_valid[i] = 1'b0;
      shadow_lru[i]   = i;
    end
  endtask

  // Pull the slot at list position pos to the front; the ones ahead shift back.
  function automatic void promote(int pos);
    int unsigned s;
    int i;
    s = shadow_lru[pos];
    for (i = pos; i > 0; i--)
      shadow_lru[i] = shadow_lru[i-1];
    shadow_lru[0] = s;
  endfunction

  // Applies one request to the shadow store and returns the answer it gives.
  function automatic tlb_answer_t tlb_predict(action_t act, logic [31:0] addr,
                                              logic [ASID_W-1:0] asid,
                                              logic [PSIZE_W-1:0] size);
    tlb_answer_t ans;
    int pos;
    int p;
    int unsigned s;
    ans.hit  = 1'b0;
    ans.slot = '0;
    case (act)
      ACT_LOOKUP, ACT_DIRTY: begin
        // Scan newest to oldest, the last position included; each entry
        // compares under its own stored page size.
        pos = -1;
        for (p = 0; p < ENTRIES && pos < 0; p++) begin
          s = shadow_lru[p];
          if (shadow_valid[s] && shadow_asid[s] == asid &&
              shadow_vpn[s] == masked_vpn(addr, shadow_psize[s]))
            pos = p;
        end
        if (pos >= 0) begin
          s = shadow_lru[pos];
          if (act == ACT_DIRTY)
            shadow_dirty[s] = 1'b1;
          promote(pos);
          ans.hit  = 1'b1;
          ans.slot = OSLOT_W'(s);
        end
      end
      ACT_FILL: begin
        // Victim is the least recent slot; an older alias stays in place.
        s = shadow_lru[ENTRIES-1];
        promote(ENTRIES - 1);
        shadow_vpn[s]   = masked_vpn(addr, size);
        shadow_asid[s]  = asid;
        shadow_psize[s] = size;
        shadow_dirty[s] = 1'b0;
        shadow_valid[s] = 1'b1;
        ans.hit  = 1'b1;
        ans.slot = OSLOT_W'(s);
      end
      default: ;  // unused code: no change, miss answer
    endcase
    return ans;
  endfunction

  // Drives one request and holds it until the transfer; called at a clock edge.
  // The expectation is queued at the transfer edge, before any response to it.
  task automatic send_request(action_t act, logic [31:0] addr,
                              logic [ASID_W-1:0] asid, logic [PSIZE_W-1:0] size);
    int gap;
    action    <= act;
    virt_addr <= addr;
    space_id  <= asid;
    page_size <= size;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall !== 1'b0);
    expected_answers.push_back(tlb_predict(act, addr, asid, size));
    // Geometric idle run; valid is only lowered when a gap follows.
    gap = 0;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct)
      gap++;
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk)
    resp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

  // Response checker: every response transfer is matched against the oldest
  // outstanding expectation.
  always @(posedge clk) begin
    if (!rst && resp_valid === 1'b1 && resp_stall == 1'b0) begin
      if (expected_answers.size() == 0) begin
        $error("unexpected response: hit %0d slot %0d", hit, slot);
        mismatches++;
      end else begin
        oldest = expected_answers.pop_front();
        if (hit !== oldest.hit) begin
          $error("hit mismatch: expected %0d, actual %0d", oldest.hit, hit);
          mismatches++;
        end
        if (slot !== oldest.slot) begin
          $error("slot mismatch: expected %0d, actual %0d", oldest.slot, slot);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Empty store: lookups, mark-dirty and the unused code all miss.
  task automatic test_cold_misses();
    idle_pct  = 0;
    stall_pct = 0;
    send_request(ACT_LOOKUP, 32'h0000_0000, 8'h00, 2'd0);
    send_request(ACT_LOOKUP, 32'hFFFF_FFFF, 8'hFF, 2'd3);
    send_request(ACT_DIRTY,  32'h1234_5678, 8'h5A, 2'd2);
    send_request(ACT_NONE,   32'hFFFF_FFFF, 8'hFF, 2'd3);
  endtask

  // One fill per page size, then a hit at the top of the page (with the
  // request's page size deliberately wrong) and a probe of the next page.
  task automatic test_page_sizes();
    page_rec_t pages [4];
    logic [31:0] low;
    int i;
    pages[0] = '{32'h0000_0000, 8'h00, 2'd0};
    pages[1] = '{32'hFFFF_FFFF, 8'hFF, 2'd1};
    pages[2] = '{32'h8001_2345, 8'h01, 2'd2};
    pages[3] = '{32'h7FF0_0000, 8'h80, 2'd3};
    for (i = 0; i < 4; i++) begin
      low = (32'h1 << page_span(pages[i].size)) - 32'h1;
      send_request(ACT_FILL, pages[i].addr, pages[i].asid, pages[i].size);
      send_request(ACT_LOOKUP, pages[i].addr | low, pages[i].asid, ~pages[i].size);
      send_request(ACT_LOOKUP, (pages[i].addr & ~low) + low + 32'h1,
                   pages[i].asid, pages[i].size);
    end
  endtask

  // Mark-dirty hit and ASID miss, then a small page aliased inside a 1M page:
  // the newer entry wins where both match.
  task automatic test_dirty_and_aliases();
    send_request(ACT_DIRTY,  32'h8001_FFFF, 8'h01, 2'd0);
    send_request(ACT_DIRTY,  32'h8001_0000, 8'h02, 2'd2);
    send_request(ACT_LOOKUP, 32'h7FFF_FFFF, 8'h80, 2'd1);
    send_request(ACT_FILL,   32'h7FF0_03FF, 8'h80, 2'd0);
    send_request(ACT_LOOKUP, 32'h7FF0_0000, 8'h80, 2'd3);
    send_request(ACT_LOOKUP, 32'h7FF0_0400, 8'h80, 2'd0);
    send_request(ACT_NONE,   32'h0000_0000, 8'h00, 2'd0);
  endtask

  // Push one entry down to the last list position and hit it there, then push
  // it down again and evict it with one more fill.
  task automatic test_full_scan();
    logic [31:0] target;
    int i;
    idle_pct  = 27;
    stall_pct = 27;
    target = $urandom;
    send_request(ACT_FILL, target, 8'hC3, 2'd1);
    for (i = 0; i < ENTRIES - 1; i++)
      send_request(ACT_FILL, $urandom, 8'h3C, PSIZE_W'($urandom_range(3)));
    send_request(ACT_LOOKUP, target, 8'hC3, 2'd0);
    for (i = 0; i < ENTRIES; i++)
      send_request(ACT_FILL, $urandom, 8'h3C, PSIZE_W'($urandom_range(3)));
    send_request(ACT_LOOKUP, target, 8'hC3, 2'd1);
  endtask

  // Some fills, mostly lookups and mark-dirty on remembered pages at
  // random offsets, some near misses, plus fully random noise.
  task automatic test_random_mix(int n_items, int unsigned idle, int unsigned stall);
    page_rec_t rec;
    logic [31:0] addr;
    logic [31:0] low;
    logic [ASID_W-1:0] asid;
    action_t act;
    int pick;
    int idx;
    int i;
    idle_pct  = idle;
    stall_pct = stall;
    for (i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (pick < 28 || recent_fills.size() == 0) begin
        addr = $urandom;
        // A crowded region makes aliases across page sizes common.
        if ($urandom_range(3) == 0)
          addr = {12'h400, 3'($urandom_range(7)), 17'($urandom)};
        asid = ($urandom_range(1) == 0) ? ASID_W'($urandom_range(3)) : ASID_W'($urandom);
        rec = '{addr, asid, PSIZE_W'($urandom_range(3))};
        send_request(ACT_FILL, rec.addr, rec.asid, rec.size);
        recent_fills.push_back(rec);
        if (recent_fills.size() > POOL_DEPTH)
          recent_fills.delete(0);
      end else if (pick < 88) begin
        rec  = recent_fills[$urandom_range(recent_fills.size() - 1)];
        low  = (32'h1 << page_span(rec.size)) - 32'h1;
        addr = (rec.addr & ~low) | ($urandom & low);
        asid = rec.asid;
        if ($urandom_range(7) == 0) begin
          idx = $urandom_range(31, page_span(rec.size));
          addr[idx] = ~addr[idx];
        end
        if ($urandom_range(9) == 0)
          asid[$urandom_range(ASID_W - 1)] ^= 1'b1;
        act = (pick < 73) ? ACT_LOOKUP : ACT_DIRTY;
        send_request(act, addr, asid, PSIZE_W'($urandom_range(3)));
      end else if (pick < 95) begin
        act = ($urandom_range(1) == 0) ? ACT_LOOKUP : ACT_DIRTY;
        send_request(act, $urandom, ASID_W'($urandom), PSIZE_W'($urandom_range(3)));
      end else begin
        send_request(ACT_NONE, $urandom, ASID_W'($urandom), PSIZE_W'($urandom_range(3)));
      end
    end
  endtask

  initial begin
    shadow_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_cold_misses();
    test_page_sizes();
    test_dirty_and_aliases();
    test_full_scan();
    test_random_mix(440, 0, 0);
    test_random_mix(440, 65, 0);
    test_random_mix(440, 0, 65);
    test_random_mix(440, 27, 27);

    // Drain: every response in, then a wait for stray ones.
    req_valid <= 1'b0;
    while (expected_answers.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
src/utlb_pkg.sv
src/utlb_cell.sv
src/utlb_front_sel.sv
src/utlb_tag_match_with_lru.sv
src/utlb_checker.sv
dv/utlb_tag_match_with_lru_test.sv
